// File: rtl/lcar_pkg.sv
// ============================================================================
// lcar_pkg: shared types and constants for the load-cell converter reader
// Holds the readout phase and controller state encodings, the command and
// status bundles between the controller and the datapath, the register map
// and the register reset values.
// ============================================================================
`default_nettype none

package lcar_pkg;

    // Fraction bits added to the dividend: Q16.16 scale in, Q8 grams out.
    localparam int FRAC_BITS = 24;

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_ZERO_OFFSET = 2'd1;
    localparam logic [1:0] REG_CNT_PER_G   = 2'd2;

    // Register reset values.
    localparam logic [15:0]        RST_HALF_PERIOD = 16'd1;
    localparam logic signed [23:0] RST_ZERO_OFFSET = 24'sd0;
    localparam logic signed [31:0] RST_CNT_PER_G   = 32'sd65536;

    // Saturation limits of the weight.
    localparam logic [31:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WEIGHT_MIN = 32'h8000_0000;

    // Phase of the serial clock line.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    // Controller states.
    typedef enum logic {
        CS_TICK,
        CS_DIV
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_tick;   // accept a tick that does not end a conversion
        logic div_start;   // accept the tick that ends a conversion
        logic load_conv;   // present the finished conversion
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_end;    // the next tick ends a conversion
        logic div_busy;    // divider is iterating
        logic out_free;    // output register can take a new transaction
    } t_status;

endpackage

`default_nettype wire

// File: rtl/lcar_div.sv
// ============================================================================
// lcar_div: signed restoring divider for the weight scaling
// Computes trunc(dividend * 2^24 / divisor), one quotient bit per cycle,
// and clips the result to signed 32 bits. A zero divisor saturates toward
// the sign of the dividend, or gives zero (still flagged) for a zero dividend.
// ============================================================================
`default_nettype none

module lcar_div
    import lcar_pkg::*;
#(
    parameter int DIFF_W = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DIFF_W-1:0] i_dividend,
    input  wire logic signed [31:0]       i_divisor,
    output logic                          o_busy,
    output logic [31:0]                   o_quotient,
    output logic                          o_sat
);

    localparam int DW = DIFF_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] r_quo, n_quo;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_div, n_div;
    logic          r_neg, n_neg;
    logic          r_dzero, n_dzero;
    logic          r_nneg, n_nneg;
    logic          r_nzero, n_nzero;

    logic [DIFF_W-1:0] mag_n;
    logic [31:0]       mag_d;
    logic [32:0]       trial;
    logic [32:0]       trial_sub;
    logic              trial_ge;
    logic              hi_nz;
    logic [31:0]       q_low;

    // Magnitudes of the operands at start.
    assign mag_n = i_dividend[DIFF_W-1] ? DIFF_W'(-i_dividend) : DIFF_W'(i_dividend);
    assign mag_d = i_divisor[31] ? 32'(-i_divisor) : 32'(i_divisor);

    // One restoring step.
    assign trial     = {r_rem, r_quo[DW-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign trial_ge  = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        n_dzero = r_dzero;
        n_nneg  = r_nneg;
        n_nzero = r_nzero;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = CW'(DW);
            n_quo   = {mag_n, {FRAC_BITS{1'b0}}};
            n_rem   = '0;
            n_div   = mag_d;
            n_neg   = i_dividend[DIFF_W-1] ^ i_divisor[31];
            n_dzero = (i_divisor == '0);
            n_nneg  = i_dividend[DIFF_W-1];
            n_nzero = (i_dividend == '0);
        end else if (r_busy) begin
            n_rem   = trial_ge ? trial_sub[31:0] : trial[31:0];
            n_quo   = {r_quo[DW-2:0], trial_ge};
            n_count = r_count - CW'(1);
            n_busy  = (r_count != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_neg   <= n_neg;
        r_dzero <= n_dzero;
        r_nneg  <= n_nneg;
        r_nzero <= n_nzero;
    end

    // Sign correction and clipping of the finished quotient.
    assign hi_nz = |r_quo[DW-1:32];
    assign q_low = r_quo[31:0];

    always_comb begin
        o_quotient = q_low;
        o_sat      = 1'b0;
        if (r_dzero) begin
            o_sat = 1'b1;
            if (r_nzero) begin
                o_quotient = '0;
            end else if (r_nneg) begin
                o_quotient = WEIGHT_MIN;
            end else begin
                o_quotient = WEIGHT_MAX;
            end
        end else if (r_neg) begin
            if (hi_nz || (q_low[31] && (|q_low[30:0]))) begin
                o_quotient = WEIGHT_MIN;
                o_sat      = 1'b1;
            end else begin
                o_quotient = 32'(-q_low);
            end
        end else if (hi_nz || q_low[31]) begin
            o_quotient = WEIGHT_MAX;
            o_sat      = 1'b1;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// File: rtl/lcar_dp.sv
// ============================================================================
// lcar_dp: datapath of the load-cell converter reader
// Holds the serial clock phase, tick and pulse counters and the shift
// register, forms the tare-corrected sample, runs the divider and keeps the
// output register and the last conversion result.
// ============================================================================
`default_nettype none

module lcar_dp
    import lcar_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic               i_data_level,
    input  wire logic [15:0]        i_half_period,
    input  wire logic signed [23:0] i_zero_offset,
    input  wire logic signed [31:0] i_counts_per_gram,
    input  wire logic               i_m_tready,
    output logic                    o_m_tvalid,
    output logic                    o_clock_level,
    output logic                    o_sample_valid,
    output logic [23:0]             o_raw_sample,
    output logic [31:0]             o_weight,
    output logic                    o_weight_sat
);

    localparam int RAW_W  = (DATA_BITS > 24) ? DATA_BITS : 24;
    localparam int DIFF_W = RAW_W + 1;
    localparam int PW     = $clog2(DATA_BITS + 1);

    t_phase               r_phase, n_phase;
    logic [PW-1:0]        r_pulse, n_pulse;
    logic [15:0]          r_tick, n_tick;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic                 r_clk, n_clk;
    logic                 r_m_tvalid, n_m_tvalid;
    logic                 r_sv, n_sv;
    logic [23:0]          r_last_raw;
    logic [31:0]          r_last_weight;
    logic                 r_last_sat;

    logic                    hp_hit;
    logic                    tick_en;
    logic signed [RAW_W-1:0] raw_ext;
    logic signed [DIFF_W-1:0] diff;
    logic                    div_busy;
    logic [31:0]             div_q;
    logic                    div_sat;

    assign tick_en = i_cmd.load_tick | i_cmd.div_start;
    assign hp_hit  = (r_tick >= i_half_period);

    // Tick-driven serial clock generation and bit capture.
    always_comb begin
        n_phase = r_phase;
        n_pulse = r_pulse;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_clk   = r_clk;
        if (tick_en) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!i_data_level) begin
                        n_phase = PH_HIGH;
                        n_clk   = 1'b1;
                        n_tick  = 16'd1;
                        n_pulse = '0;
                        n_shift = '0;
                    end
                end
                PH_HIGH: begin
                    if (hp_hit) begin
                        if (r_pulse < PW'(DATA_BITS)) begin
                            n_shift = {r_shift[DATA_BITS-2:0], i_data_level};
                        end
                        n_clk   = 1'b0;
                        n_tick  = 16'd1;
                        n_phase = PH_LOW;
                    end else begin
                        n_tick = r_tick + 16'd1;
                    end
                end
                PH_LOW: begin
                    if (hp_hit) begin
                        if (r_pulse == PW'(DATA_BITS)) begin
                            n_phase = PH_IDLE;
                            n_clk   = 1'b0;
                            n_pulse = '0;
                            n_tick  = '0;
                        end else begin
                            n_pulse = r_pulse + PW'(1);
                            n_clk   = 1'b1;
                            n_tick  = 16'd1;
                            n_phase = PH_HIGH;
                        end
                    end else begin
                        n_tick = r_tick + 16'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Sign extension of the captured word and tare subtraction.
    assign raw_ext = RAW_W'(signed'(r_shift));
    assign diff    = DIFF_W'(raw_ext) - DIFF_W'(i_zero_offset);

    lcar_div #(
        .DIFF_W (DIFF_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (diff),
        .i_divisor  (i_counts_per_gram),
        .o_busy     (div_busy),
        .o_quotient (div_q),
        .o_sat      (div_sat)
    );

    // Output register: one transaction per accepted tick.
    always_comb begin
        n_m_tvalid = r_m_tvalid;
        n_sv       = r_sv;
        if (i_cmd.load_tick) begin
            n_m_tvalid = 1'b1;
            n_sv       = 1'b0;
        end else if (i_cmd.load_conv) begin
            n_m_tvalid = 1'b1;
            n_sv       = 1'b1;
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_pulse       <= '0;
            r_tick        <= '0;
            r_shift       <= '0;
            r_clk         <= 1'b0;
            r_m_tvalid    <= 1'b0;
            r_sv          <= 1'b0;
            r_last_raw    <= '0;
            r_last_weight <= '0;
            r_last_sat    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pulse    <= n_pulse;
            r_tick     <= n_tick;
            r_shift    <= n_shift;
            r_clk      <= n_clk;
            r_m_tvalid <= n_m_tvalid;
            r_sv       <= n_sv;
            // The shift register is untouched while the divider runs.
            if (i_cmd.load_conv) begin
                r_last_raw    <= raw_ext[23:0];
                r_last_weight <= div_q;
                r_last_sat    <= div_sat;
            end
        end
    end

    assign o_status.conv_end = (r_phase == PH_LOW) && hp_hit && (r_pulse == PW'(DATA_BITS));
    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid     = r_m_tvalid;
    assign o_clock_level  = r_clk;
    assign o_sample_valid = r_sv;
    assign o_raw_sample   = r_last_raw;
    assign o_weight       = r_last_weight;
    assign o_weight_sat   = r_last_sat;

endmodule

`default_nettype wire

// File: rtl/lcar_ctrl.sv
// ============================================================================
// lcar_ctrl: controller of the load-cell converter reader
// Accepts ticks while the output register can take a transaction, and holds
// off new ticks while the divider scales a finished conversion.
// ============================================================================
`default_nettype none

module lcar_ctrl
    import lcar_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_ctrl_state r_state, n_state;
    logic        accept;

    assign accept = i_s_tvalid && o_s_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_TICK: begin
                if (accept && i_status.conv_end) begin
                    n_state = CS_DIV;
                end
            end
            CS_DIV: begin
                if (!i_status.div_busy && i_status.out_free) begin
                    n_state = CS_TICK;
                end
            end
            default: begin
                n_state = CS_TICK;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            CS_TICK: begin
                o_s_tready      = i_status.out_free;
                o_cmd.load_tick = accept && !i_status.conv_end;
                o_cmd.div_start = accept && i_status.conv_end;
            end
            CS_DIV: begin
                o_cmd.load_conv = !i_status.div_busy && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_TICK;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/load_cell_adc_reader.sv
// ============================================================================
// load_cell_adc_reader: two-wire readout of a 24-bit load-cell converter
// Top level with the configuration registers, the controller and the
// datapath.
// ============================================================================
// Each input transaction is one tick carrying the sampled data-line level,
// and each tick gives exactly one output transaction with the clock-line
// level to drive. A low data line while idle starts a transfer of DATA_BITS
// clock pulses plus one gain pulse, each phase lasting half_period_ticks
// ticks. The tick that ends a transfer carries sample_valid in tuser, the
// raw sample and the weight in grams (signed Q8, clipped, saturation flag
// set also for a zero scale). Ordinary ticks can arrive back to back
// while the output register is free. The tick that ends a transfer starts
// a restoring divider that produces one quotient bit per cycle; no new
// tick is taken until the divider is done and its result is presented.
// Registers sit at byte addresses 0 (half_period_ticks), 4 (zero_offset)
// and 8 (counts_per_gram, signed Q16.16) and should be written while idle.
// ============================================================================
`default_nettype none

module load_cell_adc_reader
    import lcar_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Tick input.
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [7:0]        i_s_axis_tdata,   // [0] data_level
    // Result output.
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [63:0]            o_m_axis_tdata,   // [0] clock_level, [24:1] raw_sample,
                                                     // [56:25] weight_grams_q8,
                                                     // [57] weight_saturated
    output logic                   o_m_axis_tuser,   // [0] sample_valid
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [15:0]        r_half_period;
    logic signed [23:0] r_zero_offset;
    logic signed [31:0] r_cnt_per_g;
    logic               cfg_wr;
    logic [1:0]         reg_idx;

    t_cmd        cmd;
    t_status     status;
    logic        clock_level;
    logic        sample_valid;
    logic [23:0] raw_sample;
    logic [31:0] weight;
    logic        weight_sat;

    // Configuration register writes.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= RST_HALF_PERIOD;
            r_zero_offset <= RST_ZERO_OFFSET;
            r_cnt_per_g   <= RST_CNT_PER_G;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HALF_PERIOD: r_half_period <= pwdata[15:0];
                REG_ZERO_OFFSET: r_zero_offset <= pwdata[23:0];
                REG_CNT_PER_G:   r_cnt_per_g   <= pwdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        unique case (reg_idx)
            REG_HALF_PERIOD: prdata = {16'd0, r_half_period};
            REG_ZERO_OFFSET: prdata = 32'(r_zero_offset);
            REG_CNT_PER_G:   prdata = r_cnt_per_g;
            default:         prdata = '0;
        endcase
    end

    lcar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lcar_dp #(
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_data_level      (i_s_axis_tdata[0]),
        .i_half_period     (r_half_period),
        .i_zero_offset     (r_zero_offset),
        .i_counts_per_gram (r_cnt_per_g),
        .i_m_tready        (i_m_axis_tready),
        .o_m_tvalid        (o_m_axis_tvalid),
        .o_clock_level     (clock_level),
        .o_sample_valid    (sample_valid),
        .o_raw_sample      (raw_sample),
        .o_weight          (weight),
        .o_weight_sat      (weight_sat)
    );

    // Output packing.
    assign o_m_axis_tdata = {6'd0, weight_sat, weight, raw_sample, clock_level};
    assign o_m_axis_tuser = sample_valid;

endmodule

`default_nettype wire
